[sv/readout_validator_with_stats_core_defines.svh]
// Assertion macros used by the readout validator checker.
`ifndef READOUT_VALIDATOR_WITH_STATS_CORE_DEFINES_SVH
`define READOUT_VALIDATOR_WITH_STATS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("readout validator check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("readout validator check failed");

`endif

[sv/rvs_pkg.sv]
// Package: types, codes and constants of the readout validator.
`timescale 1ns / 1ps
package rvs_pkg;

  localparam int ADC_BITS     = 15;
  localparam int COUNTER_BITS = 32;
  localparam int NUM_STATUS   = 9;
  localparam int STATUS_W     = 4;
  localparam int CNT_OUT_W    = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CAL_BIT      = 7;

  // Status codes, in check priority order after good.
  localparam logic [STATUS_W-1:0] ST_GOOD     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_RING     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FRONTEND = 4'd2;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_TIME     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BUNCH    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_ADC      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_CHIP     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_CHANNEL  = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RING      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRONTEND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_LENGTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME_FRAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BUNCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ADC       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHIP      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL   = 3'd7;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  typedef struct packed {
    logic [7:0]        ring;
    logic [7:0]        frontend;
    logic [15:0]       length_field;
    logic [31:0]       time_fraction;
    logic [15:0]       bunch_count;
    logic [ADC_BITS:0] threshold_adc;
    logic [7:0]        geometry;
    logic [7:0]        chip;
    logic [7:0]        channel_in;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] status_count;
    logic [CNT_OUT_W-1:0] class_count;
    logic [CNT_OUT_W-1:0] over_count;
    logic [7:0]           ring_out;
    logic [7:0]           frontend_out;
    logic [7:0]           chip_out;
    logic [7:0]           channel_out;
    logic [ADC_BITS:0]    adc_out;
    logic [15:0]          bunch_out;
    logic [31:0]          time_out;
    logic [7:0]           geometry_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0]          max_ring;
    logic [7:0]          max_frontend;
    logic [15:0]         expected_length;
    logic [31:0]         max_time_fraction;
    logic [15:0]         max_bunch_count;
    logic [ADC_BITS-1:0] max_adc;
    logic [7:0]          max_chip;
    logic [7:0]          max_channel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_ring:          8'd11,
    max_frontend:      8'd23,
    expected_length:   16'd20,
    max_time_fraction: 32'd88052499,
    max_bunch_count:   16'd4095,
    max_adc:           ADC_BITS'(1023),
    max_chip:          8'd15,
    max_channel:       8'd63
  };

  // Counter update request from the top level to the counter bank.
  typedef struct packed {
    logic                en;
    logic [STATUS_W-1:0] status;
    logic                cal;
    logic                over;
  } cnt_upd_t;

  // Counter values after the update.
  typedef struct packed {
    cnt_t status_cnt;
    cnt_t class_cnt;
    cnt_t over_cnt;
  } cnt_res_t;

endpackage

[sv/rvs_ifs.sv]
// Valid/ready channel interfaces for readout items and result items.
`timescale 1ns / 1ps
interface rvs_in_if;
  logic              valid;
  logic              ready;
  rvs_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rvs_out_if;
  logic               valid;
  logic               ready;
  rvs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/rvs_cfg_regs.sv]
// Configuration register file with write port.
`timescale 1ns / 1ps
module rvs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rvs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rvs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rvs_pkg::cfg_t                   cfg
);

  rvs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= rvs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rvs_pkg::REG_MAX_RING:      cfg_r.max_ring          <= cfg_wdata[7:0];
        rvs_pkg::REG_MAX_FRONTEND:  cfg_r.max_frontend      <= cfg_wdata[7:0];
        rvs_pkg::REG_EXP_LENGTH:    cfg_r.expected_length   <= cfg_wdata[15:0];
        rvs_pkg::REG_MAX_TIME_FRAC: cfg_r.max_time_fraction <= cfg_wdata[31:0];
        rvs_pkg::REG_MAX_BUNCH:     cfg_r.max_bunch_count   <= cfg_wdata[15:0];
        rvs_pkg::REG_MAX_ADC:       cfg_r.max_adc <= cfg_wdata[rvs_pkg::ADC_BITS-1:0];
        rvs_pkg::REG_MAX_CHIP:      cfg_r.max_chip          <= cfg_wdata[7:0];
        rvs_pkg::REG_MAX_CHANNEL:   cfg_r.max_channel       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/rvs_check.sv]
// Priority checker: first failing limit check decides the status code.
`timescale 1ns / 1ps
module rvs_check (
  input  rvs_pkg::in_item_t                item,
  input  rvs_pkg::cfg_t                    cfg,
  output logic [rvs_pkg::STATUS_W-1:0]     status
);

  always_comb begin
    if (item.ring > cfg.max_ring) begin
      status = rvs_pkg::ST_RING;
    end else if (item.frontend > cfg.max_frontend) begin
      status = rvs_pkg::ST_FRONTEND;
    end else if (item.length_field != cfg.expected_length) begin
      status = rvs_pkg::ST_LENGTH;
    end else if (item.time_fraction > cfg.max_time_fraction) begin
      status = rvs_pkg::ST_TIME;
    end else if (item.bunch_count > cfg.max_bunch_count) begin
      status = rvs_pkg::ST_BUNCH;
    end else if (item.threshold_adc[rvs_pkg::ADC_BITS-1:0] > cfg.max_adc) begin
      status = rvs_pkg::ST_ADC;
    end else if (item.chip > cfg.max_chip) begin
      status = rvs_pkg::ST_CHIP;
    end else if (item.channel_in > cfg.max_channel) begin
      status = rvs_pkg::ST_CHANNEL;
    end else begin
      status = rvs_pkg::ST_GOOD;
    end
  end

endmodule

[sv/rvs_counters.sv]
// Counter bank: status, data/calibration and over-threshold counters.
`timescale 1ns / 1ps
module rvs_counters (
  input  logic                clk,
  input  logic                rst_n,
  input  rvs_pkg::cnt_upd_t   upd,
  output rvs_pkg::cnt_res_t   res
);

  rvs_pkg::cnt_t status_cnt_r [rvs_pkg::NUM_STATUS];
  rvs_pkg::cnt_t class_cnt_r [2];
  rvs_pkg::cnt_t over_cnt_r;

  rvs_pkg::cnt_t status_nxt;
  rvs_pkg::cnt_t class_nxt;
  rvs_pkg::cnt_t over_nxt;
  logic          good;

  always_comb begin
    good       = (upd.status == rvs_pkg::ST_GOOD);
    status_nxt = rvs_pkg::cnt_t'(status_cnt_r[upd.status] + 1'b1);
    class_nxt  = rvs_pkg::cnt_t'(class_cnt_r[upd.cal] + 1'b1);
    over_nxt   = (good && upd.over) ? rvs_pkg::cnt_t'(over_cnt_r + 1'b1) : over_cnt_r;
    res.status_cnt = status_nxt;
    res.class_cnt  = good ? class_nxt : '0;
    res.over_cnt   = over_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rvs_pkg::NUM_STATUS; i++) begin
        status_cnt_r[i] <= '0;
      end
      class_cnt_r[0] <= '0;
      class_cnt_r[1] <= '0;
      over_cnt_r     <= '0;
    end else if (upd.en) begin
      status_cnt_r[upd.status] <= status_nxt;
      if (good) begin
        class_cnt_r[upd.cal] <= class_nxt;
        over_cnt_r           <= over_nxt;
      end
    end
  end

endmodule

[sv/readout_validator_with_stats_core.sv]
// Top level: readout validator with per-status and class statistics.
//
//   channel  | dir | handshake        | carries
//   ---------+-----+------------------+----------------------------------
//   in_ch    | in  | valid/ready      | one detector readout per item
//   out_ch   | out | valid/ready      | status, counts, readout fields
//   cfg_*    | in  | write enable     | limit registers, index 0..7
//
// An item is captured in the input register, then checked and counted in one
// pass and captured in the result register. Throughput is one item per cycle
// while out_ch.ready keeps the result register moving, set by the counter
// read-increment-write loop, which closes in that single pass.
// Synchronous active-low reset clears both valid flags, all counters and
// loads the default limits. A stalled result holds its register; the input
// register still takes an item while the result register is free or drains.
`timescale 1ns / 1ps
module readout_validator_with_stats_core (
  input  logic                            clk,
  input  logic                            rst_n,
  rvs_in_if.sink                          in_ch,
  rvs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rvs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rvs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rvs_pkg::cfg_t                 cfg;
  logic                          s1_valid_r;
  rvs_pkg::in_item_t             s1_item_r;
  logic                          out_valid_r;
  rvs_pkg::out_item_t            out_item_r;
  rvs_pkg::out_item_t            out_item_nxt;
  logic [rvs_pkg::STATUS_W-1:0]  status;
  rvs_pkg::cnt_upd_t             upd;
  rvs_pkg::cnt_res_t             cnt;
  logic                          adv;
  logic                          in_rdy;

  rvs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the input register into the result register when the result
  // register is empty or its item is taken this cycle.
  assign adv    = !out_valid_r || out_ch.ready;
  assign in_rdy = !s1_valid_r || adv;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_item_r <= in_ch.payload;
    end
  end

  rvs_check u_check (
    .item   (s1_item_r),
    .cfg    (cfg),
    .status (status)
  );

  // Bump counters only for the item that moves into the result register.
  always_comb begin
    upd.en     = adv && s1_valid_r;
    upd.status = status;
    upd.cal    = s1_item_r.geometry[rvs_pkg::CAL_BIT];
    upd.over   = s1_item_r.threshold_adc[rvs_pkg::ADC_BITS];
  end

  rvs_counters u_counters (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .res   (cnt)
  );

  // Assemble the result item: status, updated counts, fields passed through.
  always_comb begin
    out_item_nxt.status       = status;
    out_item_nxt.status_count = rvs_pkg::CNT_OUT_W'(cnt.status_cnt);
    out_item_nxt.class_count  = rvs_pkg::CNT_OUT_W'(cnt.class_cnt);
    out_item_nxt.over_count   = rvs_pkg::CNT_OUT_W'(cnt.over_cnt);
    out_item_nxt.ring_out     = s1_item_r.ring;
    out_item_nxt.frontend_out = s1_item_r.frontend;
    out_item_nxt.chip_out     = s1_item_r.chip;
    out_item_nxt.channel_out  = s1_item_r.channel_in;
    out_item_nxt.adc_out      = s1_item_r.threshold_adc;
    out_item_nxt.bunch_out    = s1_item_r.bunch_count;
    out_item_nxt.time_out     = s1_item_r.time_fraction;
    out_item_nxt.geometry_out = s1_item_r.geometry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Hold the result payload while stalled.
  always_ff @(posedge clk) begin
    if (upd.en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

endmodule

[sv/rvs_checker.sv]
// Port-level checker for the readout validator, with its bind.
`timescale 1ns / 1ps
`include "readout_validator_with_stats_core_defines.svh"
module rvs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input rvs_pkg::out_item_t out_item
);

  logic out_acc;
  assign out_acc = out_valid && out_ready;

  // A pending result is not withdrawn.
  `RVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Nothing leaves in the first cycle after reset.
  `RVS_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid)

  // A failed readout reports no class count.
  `RVS_ASSERT_NOW(a_fail_no_class, out_valid && out_item.status != rvs_pkg::ST_GOOD, out_item.class_count == '0)

  // Back-to-back results: a good over-threshold readout bumps the count by one.
  `RVS_ASSERT_NOW(a_over_bump, out_acc && $past(out_acc) && out_item.status == rvs_pkg::ST_GOOD && out_item.adc_out[rvs_pkg::ADC_BITS], out_item.over_count == rvs_pkg::CNT_OUT_W'($past(out_item.over_count) + 1'b1))

endmodule

bind readout_validator_with_stats_core rvs_checker u_rvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

[dv/readout_validator_with_stats_core_tb.sv]
// Testbench for the readout validator: status priority, counters and pass-through fields.
`timescale 1ns / 1ps
module readout_validator_with_stats_core_tb;
  import rvs_pkg::*;

  localparam int DIRECTED_ITEMS  = 24;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int DRAIN_CYCLES    = 4;    // margin for the pipe to empty
  localparam int HOLD_OFF_CYCLES = 80;   // long output stall, fills the pipe
  localparam int WATCHDOG_LIMIT  = 2000; // quiet cycles before giving up

  // Per-status and per-class statistics, mirrored from what the block must keep.
  class readout_status_tracker;
    cfg_t      limits;
    cnt_t      status_cnt [NUM_STATUS];
    cnt_t      class_cnt [2];
    cnt_t      over_cnt;
    out_item_t expected_results [$];
    int        mismatches;

    function new();
      limits = CFG_RESET;
      foreach (status_cnt[i]) status_cnt[i] = '0;
      class_cnt[0] = '0;
      class_cnt[1] = '0;
      over_cnt = '0;
      mismatches = 0;
    endfunction

    function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_MAX_RING:      limits.max_ring = v[7:0];
        REG_MAX_FRONTEND:  limits.max_frontend = v[7:0];
        REG_EXP_LENGTH:    limits.expected_length = v[15:0];
        REG_MAX_TIME_FRAC: limits.max_time_fraction = v[31:0];
        REG_MAX_BUNCH:     limits.max_bunch_count = v[15:0];
        REG_MAX_ADC:       limits.max_adc = v[ADC_BITS-1:0];
        REG_MAX_CHIP:      limits.max_chip = v[7:0];
        REG_MAX_CHANNEL:   limits.max_channel = v[7:0];
        default: ;
      endcase
    endfunction

    // Classify one accepted readout, bump its counters, queue the result.
    function void accept_readout(in_item_t it);
      out_item_t r;
      logic [STATUS_W-1:0] st;
      logic cal;
      if (it.ring > limits.max_ring) st = ST_RING;
      else if (it.frontend > limits.max_frontend) st = ST_FRONTEND;
      else if (it.length_field != limits.expected_length) st = ST_LENGTH;
      else if (it.time_fraction > limits.max_time_fraction) st = ST_TIME;
      else if (it.bunch_count > limits.max_bunch_count) st = ST_BUNCH;
      else if (it.threshold_adc[ADC_BITS-1:0] > limits.max_adc) st = ST_ADC;
      else if (it.chip > limits.max_chip) st = ST_CHIP;
      else if (it.channel_in > limits.max_channel) st = ST_CHANNEL;
      else st = ST_GOOD;
      r = '0;
      status_cnt[st] = status_cnt[st] + 1'b1;
      r.status = st;
      r.status_count = status_cnt[st];
      // Only a good readout touches the class and over-threshold counters.
      if (st == ST_GOOD) begin
        if (it.threshold_adc[ADC_BITS]) over_cnt = over_cnt + 1'b1;
        cal = it.geometry[CAL_BIT];
        class_cnt[cal] = class_cnt[cal] + 1'b1;
        r.class_count = class_cnt[cal];
      end
      r.over_count   = over_cnt;
      r.ring_out     = it.ring;
      r.frontend_out = it.frontend;
      r.chip_out     = it.chip;
      r.channel_out  = it.channel_in;
      r.adc_out      = it.threshold_adc;
      r.bunch_out    = it.bunch_count;
      r.time_out     = it.time_fraction;
      r.geometry_out = it.geometry;
      expected_results = {expected_results, r};
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    function void field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) flag(what, want, got);
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no readout pending, status 0x%0h", $time, got.status);
        return;
      end
      want = expected_results.pop_front();
      field("status", 32'(want.status), 32'(got.status));
      field("status_count", want.status_count, got.status_count);
      field("class_count", want.class_count, got.class_count);
      field("over_count", want.over_count, got.over_count);
      field("ring_out", 32'(want.ring_out), 32'(got.ring_out));
      field("frontend_out", 32'(want.frontend_out), 32'(got.frontend_out));
      field("chip_out", 32'(want.chip_out), 32'(got.chip_out));
      field("channel_out", 32'(want.channel_out), 32'(got.channel_out));
      field("adc_out", 32'(want.adc_out), 32'(got.adc_out));
      field("bunch_out", 32'(want.bunch_out), 32'(got.bunch_out));
      field("time_out", want.time_out, got.time_out);
      field("geometry_out", 32'(want.geometry_out), 32'(got.geometry_out));
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rvs_in_if  in_ch ();
  rvs_out_if out_ch ();

  readout_validator_with_stats_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  readout_status_tracker stats = new();

  int in_idle_pct;    // chance in percent that the sender skips a cycle
  int out_idle_pct;   // chance in percent that the receiver stalls a cycle
  bit hold_off_req;   // raised by the stimulus, consumed by the receiver
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels at the edge; inputs are driven with NBAs, so every
  // value read here is the one the block saw at this same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) stats.compare_result(out_ch.payload);
      if (in_ch.valid && in_ch.ready) stats.accept_readout(in_ch.payload);
    end
  end

  // Watchdog: give up when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("readout_validator_with_stats_core_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so the
  // block fills and must back-pressure the sender.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  function automatic in_item_t noise_readout();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  // Value within a limit, often the limit itself.
  function automatic logic [31:0] pick_ok(logic [31:0] lim);
    return ($urandom_range(3) == 0) ? lim : $urandom_range(lim, 0);
  endfunction

  // Value beyond a limit, often just one above it; lim must be below top.
  function automatic logic [31:0] pick_bad(logic [31:0] lim, logic [31:0] top);
    return ($urandom_range(3) == 0) ? lim + 1 : $urandom_range(top, lim + 1);
  endfunction

  // Build a readout that passes every check, then break the one check that
  // target names; checks below the target are left random half the time.
  function automatic in_item_t random_readout(cfg_t c);
    in_item_t it;
    logic [STATUS_W-1:0] target;
    logic [15:0] delta;
    if ($urandom_range(7) == 0) return noise_readout();
    target = ($urandom_range(9) < 3) ? ST_GOOD
                                     : STATUS_W'($urandom_range(ST_CHANNEL, ST_RING));
    it.ring          = 8'(pick_ok(32'(c.max_ring)));
    it.frontend      = 8'(pick_ok(32'(c.max_frontend)));
    it.length_field  = c.expected_length;
    it.time_fraction = pick_ok(c.max_time_fraction);
    it.bunch_count   = 16'(pick_ok(32'(c.max_bunch_count)));
    it.threshold_adc = {1'($urandom), ADC_BITS'(pick_ok(32'(c.max_adc)))};
    it.geometry      = 8'($urandom);
    it.chip          = 8'(pick_ok(32'(c.max_chip)));
    it.channel_in    = 8'(pick_ok(32'(c.max_channel)));
    case (target)
      ST_RING:     if (c.max_ring != 8'hff)
                     it.ring = 8'(pick_bad(32'(c.max_ring), 32'hff));
      ST_FRONTEND: if (c.max_frontend != 8'hff)
                     it.frontend = 8'(pick_bad(32'(c.max_frontend), 32'hff));
      ST_LENGTH: begin
        delta = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'h0001 : 16'hffff)
                                         : 16'($urandom_range(16'hffff, 1));
        it.length_field = c.expected_length + delta;
      end
      ST_TIME:     if (c.max_time_fraction != 32'hffff_ffff)
                     it.time_fraction = pick_bad(c.max_time_fraction, 32'hffff_ffff);
      ST_BUNCH:    if (c.max_bunch_count != 16'hffff)
                     it.bunch_count = 16'(pick_bad(32'(c.max_bunch_count), 32'hffff));
      ST_ADC:      if (c.max_adc != '1)
                     it.threshold_adc[ADC_BITS-1:0] =
                       ADC_BITS'(pick_bad(32'(c.max_adc), 32'({ADC_BITS{1'b1}})));
      ST_CHIP:     if (c.max_chip != 8'hff)
                     it.chip = 8'(pick_bad(32'(c.max_chip), 32'hff));
      ST_CHANNEL:  if (c.max_channel != 8'hff)
                     it.channel_in = 8'(pick_bad(32'(c.max_channel), 32'hff));
      default: ;
    endcase
    // Scramble the lower-priority fields: the first failure must still win.
    if (target != ST_GOOD && $urandom_range(1)) begin
      if (target < ST_FRONTEND) it.frontend = 8'($urandom);
      if (target < ST_LENGTH) it.length_field = 16'($urandom);
      if (target < ST_TIME) it.time_fraction = $urandom;
      if (target < ST_BUNCH) it.bunch_count = 16'($urandom);
      if (target < ST_ADC) it.threshold_adc = 16'($urandom);
      if (target < ST_CHIP) it.chip = 8'($urandom);
      if (target < ST_CHANNEL) it.channel_in = 8'($urandom);
    end
    return it;
  endfunction

  // Directed readouts under the reset limits: boundaries on both sides,
  // field extremes, check priority, and the flag bit on good and bad items.
  function automatic in_item_t directed_readout(int k);
    in_item_t it;
    it = '0;
    it.length_field = CFG_RESET.expected_length;
    case (k)
      1: begin
        it.ring = CFG_RESET.max_ring;
        it.frontend = CFG_RESET.max_frontend;
        it.time_fraction = CFG_RESET.max_time_fraction;
        it.bunch_count = CFG_RESET.max_bunch_count;
        it.threshold_adc = {1'b1, CFG_RESET.max_adc};
        it.chip = CFG_RESET.max_chip;
        it.channel_in = CFG_RESET.max_channel;
        it.geometry = 8'h80;
      end
      2: begin
        it.ring = CFG_RESET.max_ring + 8'd1;
        it.threshold_adc = 16'h8000;
      end
      3: it = '1;
      4: it.frontend = CFG_RESET.max_frontend + 8'd1;
      5: begin
        it.frontend = 8'hff;
        it.length_field = 16'h0000;
      end
      6: it.length_field = CFG_RESET.expected_length - 16'd1;
      7: it.length_field = CFG_RESET.expected_length + 16'd1;
      8: it.length_field = 16'hffff;
      9: it.time_fraction = CFG_RESET.max_time_fraction + 32'd1;
      10: it.time_fraction = 32'hffff_ffff;
      11: it.bunch_count = CFG_RESET.max_bunch_count + 16'd1;
      12: it.bunch_count = 16'hffff;
      13: it.threshold_adc = {1'b0, CFG_RESET.max_adc + ADC_BITS'(1)};
      14: it.threshold_adc = 16'h7fff;
      15: it.threshold_adc = 16'h8000;
      16: begin
        it.threshold_adc = {1'b1, CFG_RESET.max_adc};
        it.geometry = 8'h7f;
      end
      17: it.threshold_adc = {1'b1, ADC_BITS'(CFG_RESET.max_adc + 1)};
      18: it.chip = CFG_RESET.max_chip + 8'd1;
      19: it.chip = 8'hff;
      20: it.channel_in = CFG_RESET.max_channel + 8'd1;
      21: it.channel_in = 8'hff;
      22: it.geometry = 8'hff;
      23: begin
        it.chip = CFG_RESET.max_chip + 8'd1;
        it.channel_in = CFG_RESET.max_channel + 8'd1;
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic cfg_t random_limits();
    cfg_t c;
    c.max_ring          = 8'($urandom);
    c.max_frontend      = 8'($urandom);
    c.expected_length   = 16'($urandom);
    c.max_time_fraction = $urandom;
    c.max_bunch_count   = 16'($urandom);
    c.max_adc           = ADC_BITS'($urandom);
    c.max_chip          = 8'($urandom);
    c.max_channel       = 8'($urandom);
    return c;
  endfunction

  // Limits per random phase: widest, narrowest, defaults, and random sets.
  function automatic cfg_t phase_limits(int p);
    cfg_t c;
    case (p)
      0: begin
        c = '1;
        c.expected_length = 16'($urandom);
      end
      1: c = '0;
      4: c = CFG_RESET;
      default: c = random_limits();
    endcase
    return c;
  endfunction

  // Offer one readout, idling at random first; hold valid until taken.
  task automatic send_readout(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= noise_readout();
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, let the last accepted item be noted, wait for every pending
  // result, then let the pipe empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (stats.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight limit registers back to back; junk above each width.
  task automatic load_limits(cfg_t c);
    logic [CFG_DATA_W-1:0] v;
    for (int i = REG_MAX_RING; i <= REG_MAX_CHANNEL; i++) begin
      v = $urandom;
      case (CFG_IDX_W'(i))
        REG_MAX_RING:      v[7:0] = c.max_ring;
        REG_MAX_FRONTEND:  v[7:0] = c.max_frontend;
        REG_EXP_LENGTH:    v[15:0] = c.expected_length;
        REG_MAX_TIME_FRAC: v = c.max_time_fraction;
        REG_MAX_BUNCH:     v[15:0] = c.max_bunch_count;
        REG_MAX_ADC:       v[ADC_BITS-1:0] = c.max_adc;
        REG_MAX_CHIP:      v[7:0] = c.max_chip;
        REG_MAX_CHANNEL:   v[7:0] = c.max_channel;
        default: ;
      endcase
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      cfg_wdata <= v;
      stats.write_limit(CFG_IDX_W'(i), v);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        in_idle_pct = 38;
        out_idle_pct = 55;
      end
      1: begin
        in_idle_pct = 55;
        out_idle_pct = 38;
      end
      default: begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    hold_off_req = 1'b0;
    quiet_cycles = 0;
    set_idling(0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs on the reset limits, nothing written yet.
    for (int k = 0; k < DIRECTED_ITEMS; k++) send_readout(directed_readout(k));

    // Random part: two phases per idling mode, new limits for each phase.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_limits(phase_limits(p));
      set_idling(p / 2);
      if (p == 4) hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_readout(random_readout(stats.limits));
    end
    settle();

    if (stats.mismatches == 0) begin
      $display("readout_validator_with_stats_core_tb passed");
    end else begin
      $display("readout_validator_with_stats_core_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rvs_pkg.sv
sv/rvs_ifs.sv
sv/rvs_cfg_regs.sv
sv/rvs_check.sv
sv/rvs_counters.sv
sv/readout_validator_with_stats_core.sv
sv/rvs_checker.sv
dv/readout_validator_with_stats_core_tb.sv
